### hdl/rtsptis_pkg.sv
package rtsptis_pkg;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    // Result queue depth; must be a power of two and at least 4
    localparam int OUTQ_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        KIND_TOKEN_BYTE = 3'd0,
        KIND_END_SPACE  = 3'd1,
        KIND_END_LINE   = 3'd2,
        KIND_HDR_END    = 3'd3,
        KIND_FRAME      = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [7:0]  channel;
        logic [15:0] frame_length;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

endpackage

### hdl/rtsptis_parse.sv
module rtsptis_parse
    import rtsptis_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step_en,
    input  logic [7:0]   in_byte,
    input  logic         split_on_space,
    output result_pair_t results
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CHAN   = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_SKIP   = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic        held_vld_reg, held_vld_next;
    logic        nonempty_reg, nonempty_next;
    logic        absorb_reg, absorb_next;
    logic [7:0]  chan_reg, chan_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] remain_reg, remain_next;

    logic        is_delim;
    logic        is_space_end;
    logic [15:0] flen;
    logic        emit_tok;
    logic        emit_end;
    logic        emit_frame;
    kind_t       end_kind;
    result_t     tok_res;
    result_t     end_res;
    result_t     frame_res;

    assign is_space_end = split_on_space && (in_byte == CH_SP);
    assign is_delim     = (in_byte == CH_CR) || (in_byte == CH_LF) || is_space_end;
    assign flen         = {len_reg[15:8], in_byte};

    always_comb begin
        phase_next    = phase_reg;
        held_next     = held_reg;
        held_vld_next = held_vld_reg;
        nonempty_next = nonempty_reg;
        absorb_next   = absorb_reg;
        chan_next     = chan_reg;
        len_next      = len_reg;
        remain_next   = remain_reg;
        emit_tok      = 1'b0;
        emit_end      = 1'b0;
        emit_frame    = 1'b0;
        end_kind      = KIND_HDR_END;

        unique case (phase_reg)
            PH_CHAN: begin
                chan_next  = in_byte;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_next   = {in_byte, 8'h00};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_next = flen;
                if (flen == 16'h0000) begin
                    phase_next = PH_IDLE;
                    emit_frame = 1'b1;
                end else begin
                    remain_next = flen;
                    phase_next  = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (remain_reg > 16'd1) begin
                    remain_next = remain_reg - 16'd1;
                end else begin
                    remain_next = 16'h0000;
                    phase_next  = PH_IDLE;
                    emit_frame  = 1'b1;
                end
            end
            default: begin
                phase_next  = PH_IDLE;
                absorb_next = 1'b0;
                // drop one delimiter straight after the terminating one
                if (!(absorb_reg && is_delim)) begin
                    if (is_delim) begin
                        emit_tok = held_vld_reg && (held_reg != CH_COLON);
                        emit_end = 1'b1;
                        if (nonempty_reg || emit_tok) begin
                            end_kind = is_space_end ? KIND_END_SPACE : KIND_END_LINE;
                        end else begin
                            end_kind = KIND_HDR_END;
                        end
                        held_vld_next = 1'b0;
                        held_next     = 8'h00;
                        nonempty_next = 1'b0;
                        absorb_next   = 1'b1;
                    end else if (!held_vld_reg && !nonempty_reg && in_byte == CH_DOLLAR) begin
                        phase_next = PH_CHAN;
                    end else begin
                        if (held_vld_reg) begin
                            emit_tok      = 1'b1;
                            nonempty_next = 1'b1;
                        end
                        held_next     = in_byte;
                        held_vld_next = 1'b1;
                    end
                end
            end
        endcase
    end

    always_comb begin
        tok_res           = '0;
        tok_res.kind      = KIND_TOKEN_BYTE;
        tok_res.data_byte = held_reg;
        tok_res.last      = !emit_end;

        end_res      = '0;
        end_res.kind = end_kind;
        end_res.last = 1'b1;

        frame_res              = '0;
        frame_res.kind         = KIND_FRAME;
        frame_res.channel      = chan_reg;
        frame_res.frame_length = (phase_reg == PH_LEN_LO) ? 16'h0000 : len_reg;
        frame_res.last         = 1'b1;

        results        = '0;
        results.first  = frame_res;
        results.second = end_res;
        if (emit_frame) begin
            results.count = 2'd1;
        end else if (emit_tok) begin
            results.first = tok_res;
            results.count = emit_end ? 2'd2 : 2'd1;
        end else if (emit_end) begin
            results.first = end_res;
            results.count = 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            held_reg     <= 8'h00;
            held_vld_reg <= 1'b0;
            nonempty_reg <= 1'b0;
            absorb_reg   <= 1'b0;
            chan_reg     <= 8'h00;
            len_reg      <= 16'h0000;
            remain_reg   <= 16'h0000;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            held_reg     <= held_next;
            held_vld_reg <= held_vld_next;
            nonempty_reg <= nonempty_next;
            absorb_reg   <= absorb_next;
            chan_reg     <= chan_next;
            len_reg      <= len_next;
            remain_reg   <= remain_next;
        end
    end

endmodule

### hdl/rtsptis_outq.sv
module rtsptis_outq
    import rtsptis_pkg::*;
#(
    parameter int DEPTH = OUTQ_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_en,
    input  result_pair_t push_data,
    output logic         room,
    output logic         out_valid,
    input  logic         out_ready,
    output result_t      out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_reg, wr_next;
    logic [PTR_W-1:0]     rd_reg, rd_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [1:0]           push_cnt;
    logic                 pop;

    assign push_cnt  = push_en ? push_data.count : 2'd0;
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_reg[rd_reg];
    // room for a full pair regardless of what the output side does this cycle
    assign room      = (cnt_reg <= CNT_W'(DEPTH - 2));

    assign wr_next  = wr_reg + PTR_W'(push_cnt);
    assign rd_next  = rd_reg + PTR_W'(pop);
    assign cnt_next = cnt_reg + CNT_W'(push_cnt) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            entry_reg[wr_reg] <= push_data.first;
        end
        if (push_cnt == 2'd2) begin
            entry_reg[wr_reg + PTR_W'(1)] <= push_data.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### hdl/rtsp_token_and_interleave_splitter_unit.sv
// Channel | Direction | Handshake        | Payload
// s_      | in        | s_tvalid/tready  | tdata: in_byte; tuser: split_on_space
// m_      | out       | m_tvalid/tready  | tdata: data_byte, channel, frame_length;
//         |           |                  | tuser: kind; tlast: last
//
// A byte is taken into an input register, parsed combinationally and its results
// (none, one or two) written to a small result queue; one byte per cycle is
// sustained while each byte yields at most one result and the queue has room;
// the input register and the result queue lie between input and first result.
// s_tready depends only on registered state: the input register and the queue
// fill level. Reset (aresetn low, synchronous) clears parser state and queue.
module rtsp_token_and_interleave_splitter_unit
    import rtsptis_pkg::*;
#(
    parameter int OUTQ_DEPTH = OUTQ_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] split_on_space
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] data_byte, [15:8] channel, [31:16] frame_length
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast
);

    logic         in_vld_reg;
    logic [7:0]   in_byte_reg;
    logic         in_sp_reg;
    logic         q_room;
    logic         consume;
    result_pair_t parse_res;
    result_t      q_out;

    assign consume  = in_vld_reg && q_room;
    assign s_tready = !in_vld_reg || q_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_sp_reg   <= s_tuser;
        end
    end

    rtsptis_parse u_parse (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (consume),
        .in_byte        (in_byte_reg),
        .split_on_space (in_sp_reg),
        .results        (parse_res)
    );

    rtsptis_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (consume),
        .push_data (parse_res),
        .room      (q_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (q_out)
    );

    assign m_tdata = {q_out.frame_length, q_out.channel, q_out.data_byte};
    assign m_tuser = q_out.kind;
    assign m_tlast = q_out.last;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rtsptis_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_BYTES = 1700;
    localparam logic [7:0] CH_A = 8'h41;

    // Expected-result tracker: mirrors the splitter's parse state.
    class token_tracker;
        typedef enum logic [2:0] {
            PH_IDLE    = 3'd0,
            PH_CHANNEL = 3'd1,
            PH_LEN_HI  = 3'd2,
            PH_LEN_LO  = 3'd3,
            PH_PAYLOAD = 3'd4
        } phase_t;

        phase_t      phase;
        logic [7:0]  held;
        logic        held_ok;
        logic        nonempty;
        logic        skip_delim;
        logic [7:0]  chan;
        logic [7:0]  len_hi;
        logic [7:0]  len_lo;
        logic [15:0] remaining;
        result_t     expected_q[$];
        int          mismatches;

        function new();
            phase = PH_IDLE;
            held = 8'h00;
            held_ok = 1'b0;
            nonempty = 1'b0;
            skip_delim = 1'b0;
            chan = 8'h00;
            len_hi = 8'h00;
            len_lo = 8'h00;
            remaining = 16'h0000;
            mismatches = 0;
        endfunction

        function result_t entry(kind_t k, logic [7:0] d, logic [7:0] c, logic [15:0] l);
            result_t r;
            r.kind = k;
            r.data_byte = d;
            r.channel = c;
            r.frame_length = l;
            r.last = 1'b0;
            return r;
        endfunction

        function bit at_token_start();
            return phase == PH_IDLE && !held_ok && !nonempty;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // Note one accepted input transaction and queue what it yields.
        function void take_byte(logic [7:0] b, logic sp);
            result_t step_q[$];
            result_t r;
            logic    delim;
            kind_t   end_kind;
            delim = (b == CH_CR) || (b == CH_LF) || (sp && b == CH_SP);
            case (phase)
                PH_CHANNEL: begin
                    chan = b;
                    phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len_hi = b;
                    phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_lo = b;
                    if ({len_hi, len_lo} == 16'h0000) begin
                        phase = PH_IDLE;
                        step_q.push_back(entry(KIND_FRAME, 8'h00, chan, 16'h0000));
                    end else begin
                        remaining = {len_hi, len_lo};
                        phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (remaining > 16'd1) begin
                        remaining = remaining - 16'd1;
                    end else begin
                        remaining = 16'h0000;
                        phase = PH_IDLE;
                        step_q.push_back(entry(KIND_FRAME, 8'h00, chan, {len_hi, len_lo}));
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    if (skip_delim && delim) begin
                        // drop the second byte of a delimiter pair
                        skip_delim = 1'b0;
                    end else begin
                        skip_delim = 1'b0;
                        if (delim) begin
                            if (held_ok && held != CH_COLON) begin
                                step_q.push_back(entry(KIND_TOKEN_BYTE, held, 8'h00, 16'h0000));
                                nonempty = 1'b1;
                            end
                            end_kind = (sp && b == CH_SP) ? KIND_END_SPACE : KIND_END_LINE;
                            if (!nonempty)
                                end_kind = KIND_HDR_END;
                            step_q.push_back(entry(end_kind, 8'h00, 8'h00, 16'h0000));
                            held_ok = 1'b0;
                            held = 8'h00;
                            nonempty = 1'b0;
                            skip_delim = 1'b1;
                        end else if (!held_ok && !nonempty && b == CH_DOLLAR) begin
                            phase = PH_CHANNEL;
                        end else begin
                            if (held_ok) begin
                                step_q.push_back(entry(KIND_TOKEN_BYTE, held, 8'h00, 16'h0000));
                                nonempty = 1'b1;
                            end
                            held = b;
                            held_ok = 1'b1;
                        end
                    end
                end
            endcase
            foreach (step_q[i]) begin
                r = step_q[i];
                r.last = (i == step_q.size() - 1);
                expected_q.push_back(r);
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void match_result(logic [2:0] kind, logic [7:0] data, logic [7:0] ch,
                                   logic [15:0] len, logic last);
            result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %s",
                         $time, "kind/data/ch/len/last");
                $display("%0t:     %h %h %h %h %b", $time, kind, data, ch, len, last);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", 16'(want.kind), 16'(kind));
            compare_field("data_byte", 16'(want.data_byte), 16'(data));
            compare_field("channel", 16'(want.channel), 16'(ch));
            compare_field("frame_length", want.frame_length, len);
            compare_field("last", 16'(want.last), 16'(last));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    token_tracker tracker;
    logic calm = 1'b0;
    bit   steady;
    int   bytes_sent;
    int   cycles;
    int   stall_left;

    rtsp_token_and_interleave_splitter_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stall bursts, none once the run calms down.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.match_result(m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[31:16], m_tlast);
    end

    task automatic put_byte(input logic [7:0] b, input logic sp);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= sp;
        do @(posedge aclk); while (!s_tready);
        tracker.take_byte(b, sp);
        bytes_sent++;
        if (!calm && !steady && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    // Hold off the sender until every queued result has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.outstanding() != 0);
    endtask

    function automatic logic [7:0] noisy_byte();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0: b = CH_CR;
            1: b = CH_LF;
            2: b = CH_SP;
            3: b = CH_COLON;
            4: b = 8'h00;
            5: b = 8'hFF;
            default: begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_DOLLAR)
                    b = 8'h25;
            end
        endcase
        return b;
    endfunction

    task automatic send_token(input logic sp);
        int         n;
        logic [7:0] b;
        n = int'($urandom_range(1, 8));
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_CR || b == CH_LF || b == CH_DOLLAR || (sp && b == CH_SP))
                b = 8'(CH_A + $urandom_range(0, 25));
            if (i > 0 && $urandom_range(0, 9) == 0)
                b = CH_DOLLAR;
            if (i == n - 1 && $urandom_range(0, 2) == 0)
                b = CH_COLON;
            put_byte(b, sp);
        end
        case ($urandom_range(0, 4))
            0: begin
                put_byte(CH_CR, sp);
                put_byte(CH_LF, sp);
            end
            1: put_byte(CH_CR, sp);
            2: put_byte(CH_LF, sp);
            3: put_byte(sp ? CH_SP : CH_LF, sp);
            default: begin
                put_byte(CH_SP, 1'b1);
                put_byte(CH_SP, 1'b1);
            end
        endcase
    endtask

    task automatic send_frame(input logic [15:0] len, input logic sp);
        if (!tracker.at_token_start())
            put_byte(CH_CR, sp);
        put_byte(CH_DOLLAR, sp);
        put_byte(8'($urandom_range(0, 255)), sp);
        put_byte(len[15:8], 1'($urandom_range(0, 1)));
        put_byte(len[7:0], 1'($urandom_range(0, 1)));
        for (int i = 0; i < len; i++)
            put_byte(($urandom_range(0, 1) != 0) ? noisy_byte() : 8'($urandom),
                     1'($urandom_range(0, 1)));
    endtask

    task automatic send_random_sequence();
        logic        sp;
        int          pick;
        logic [15:0] len;
        sp = 1'($urandom_range(0, 1));
        pick = int'($urandom_range(0, 19));
        if (pick < 11) begin
            send_token(sp);
        end else if (pick < 14) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = 16'($urandom_range(0, 6));
                6, 7, 8: len = 16'($urandom_range(7, 40));
                default: len = 16'($urandom_range(41, 300));
            endcase
            send_frame(len, sp);
        end else if (pick < 16) begin
            put_byte(CH_CR, sp);
            put_byte(CH_LF, sp);
        end else begin
            repeat ($urandom_range(1, 6))
                put_byte(noisy_byte(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int  random_start;
        bit  bulk_done;
        bit  drained_mid;
        tracker = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // token with trailing colon, then a delimiter pair
        put_byte(CH_A, 1'b1);
        put_byte(CH_COLON, 1'b1);
        put_byte(CH_CR, 1'b1);
        put_byte(CH_LF, 1'b1);
        // lone colon: empty token, end of headers
        put_byte(CH_COLON, 1'b0);
        put_byte(CH_CR, 1'b0);
        // dollar straight after a delimiter: zero-length frame
        put_byte(CH_DOLLAR, 1'b1);
        put_byte(8'hFF, 1'b1);
        put_byte(8'h00, 1'b1);
        put_byte(8'h00, 1'b1);
        // one-byte frame whose payload is a delimiter
        put_byte(CH_DOLLAR, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h01, 1'b0);
        put_byte(CH_CR, 1'b1);
        // space and NUL as token bytes, dollar mid-token, ended by space
        put_byte(CH_SP, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(CH_DOLLAR, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(CH_SP, 1'b1);
        put_byte(CH_SP, 1'b1);
        put_byte(CH_CR, 1'b1);
        put_byte(CH_LF, 1'b1);
        wait_drained();

        random_start = bytes_sent;
        bulk_done = 0;
        drained_mid = 0;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            if (!bulk_done && bytes_sent - random_start > 900) begin
                // long frame, sent back to back
                bulk_done = 1;
                steady = 1;
                send_frame(16'h0100, 1'b1);
                steady = 0;
            end
            if (!drained_mid && bytes_sent - random_start > 600) begin
                drained_mid = 1;
                wait_drained();
            end
            if (bytes_sent - random_start > RANDOM_BYTES - 200)
                calm <= 1'b1;
            send_random_sequence();
        end
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (tracker.outstanding() != 0);
        repeat (10) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
hdl/rtsptis_pkg.sv
hdl/rtsptis_parse.sv
hdl/rtsptis_outq.sv
hdl/rtsp_token_and_interleave_splitter_unit.sv
tb/testbench.sv
